// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the heap queue.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("heap queue assertion failed");

// Condition in one cycle that demands another in the next cycle.
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue assertion failed");

`endif

// ===== rtl/bmhq_pkg.sv =====
// Package of the heap queue: word types, codes and controller/datapath structs.
// Depends on nothing; used by bmhq_ctrl, bmhq_dp and the top level.
package bmhq_pkg;

   localparam int ID_BITS        = 10;
   localparam int NUM_IDS        = 1024;
   localparam int CMD_BITS       = 2;
   localparam int IN_KEY_BITS    = 32;
   localparam int DELTA_BITS     = 31;
   localparam int COUNT_OUT_BITS = 11;
   localparam int STATUS_BITS    = 3;

   localparam logic [CMD_BITS-1:0] CMD_INSERT     = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE_MIN = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DECREASE   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_PRESENT = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_ABSENT  = 3'd4;

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [ID_BITS-1:0]     item_id;
      logic [IN_KEY_BITS-1:0] new_key;
      logic [DELTA_BITS-1:0]  delta;
   } req_word_type;

   typedef struct packed {
      logic [ID_BITS-1:0]        removed_id;
      logic [IN_KEY_BITS-1:0]    removed_key;
      logic [ID_BITS-1:0]        min_id;
      logic [IN_KEY_BITS-1:0]    min_key;
      logic                      is_empty;
      logic [COUNT_OUT_BITS-1:0] entry_count;
      logic [STATUS_BITS-1:0]    status;
   } rsp_word_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LOAD,
      DP_SET_STATUS,
      DP_RD_ROOT,
      DP_TAKE_ROOT,
      DP_LOAD_LAST,
      DP_INS_START,
      DP_DEC_READ,
      DP_DEC_APPLY,
      DP_UP_READ,
      DP_UP_STEP,
      DP_DN_READ_L,
      DP_DN_READ_R,
      DP_DN_STEP,
      DP_PLACE,
      DP_FIN_READ,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [STATUS_BITS-1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                clear_done;
      logic                is_present;
      logic                full;
      logic                empty;
      logic                last_one;
      logic                pos_zero;
      logic                up_stop;
      logic                no_left;
      logic                dn_stop;
      logic                slot_ok;
      logic                out_busy;
      logic [CMD_BITS-1:0] cmd;
   } dp_stat_type;

endpackage

// ===== rtl/bmhq_stream_if.sv =====
// Valid/ready channel interface of the heap queue, one word type per instance.
// Depends on nothing; the word types come from bmhq_pkg where it is used.
interface bmhq_stream_if #(parameter type word_type = logic);

   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/bmhq_ctrl.sv =====
// Controller of the heap queue: sequences clear, command decode and sifting.
// Depends on bmhq_pkg; drives bmhq_dp through ctrl_cmd_type commands.
module bmhq_ctrl import bmhq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dp_stat_type  stat,
   input  logic         req_valid,
   output logic         req_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_TAKE, S_LAST, S_DEC_APPLY, S_UP_RD, S_UP_CMP,
      S_DN_RDL, S_DN_RDR, S_DN_CMP, S_PLACE, S_FIN, S_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = DP_NOP;
      cmd.status = STATUS_OK;
      req_ready  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FIN;
            case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.is_present) begin
                     cmd.op     = DP_SET_STATUS;
                     cmd.status = STATUS_PRESENT;
                  end else if (stat.full) begin
                     cmd.op     = DP_SET_STATUS;
                     cmd.status = STATUS_FULL;
                  end else begin
                     cmd.op   = DP_INS_START;
                     state_in = S_UP_RD;
                  end
               end
               CMD_DELETE_MIN: begin
                  if (stat.empty) begin
                     cmd.op     = DP_SET_STATUS;
                     cmd.status = STATUS_EMPTY;
                  end else begin
                     cmd.op   = DP_RD_ROOT;
                     state_in = S_TAKE;
                  end
               end
               CMD_DECREASE: begin
                  if (!stat.is_present) begin
                     cmd.op     = DP_SET_STATUS;
                     cmd.status = STATUS_ABSENT;
                  end else begin
                     cmd.op = DP_DEC_READ;
                     if (stat.slot_ok) state_in = S_DEC_APPLY;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_TAKE: begin
            cmd.op   = DP_TAKE_ROOT;
            state_in = stat.last_one ? S_FIN : S_LAST;
         end
         S_LAST: begin
            cmd.op   = DP_LOAD_LAST;
            state_in = S_DN_RDL;
         end
         S_DEC_APPLY: begin
            cmd.op   = DP_DEC_APPLY;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = DP_UP_READ;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_stop) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = DP_UP_STEP;
               state_in = S_UP_RD;
            end
         end
         S_DN_RDL: begin
            if (stat.no_left) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = DP_DN_READ_L;
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            cmd.op   = DP_DN_READ_R;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_stop) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = DP_DN_STEP;
               state_in = S_DN_RDL;
            end
         end
         S_PLACE: begin
            cmd.op   = DP_PLACE;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = DP_FIN_READ;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!stat.out_busy) begin
               cmd.op   = DP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bmhq_dp.sv =====
// Datapath of the heap queue: slot and id memories, working entry, compares.
// Depends on bmhq_pkg and assert_macros.svh; commanded by bmhq_ctrl.
`include "assert_macros.svh"

module bmhq_dp import bmhq_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  req_word_type req_word,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int LW  = AW + 2;
   localparam int EW  = ((KEY_BITS > IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS) + 2;
   localparam int CLW = $clog2(NUM_IDS);
   localparam logic [EW-1:0] KMIN = {{(EW-KEY_BITS+1){1'b1}}, {(KEY_BITS-1){1'b0}}};
   localparam logic [EW-1:0] KMAX = {{(EW-KEY_BITS+1){1'b0}}, {(KEY_BITS-1){1'b1}}};

   logic [KEY_BITS-1:0] key_mem     [CAPACITY];
   logic [ID_BITS-1:0]  item_mem    [CAPACITY];
   logic [AW-1:0]       slot_mem    [NUM_IDS];
   logic                present_mem [NUM_IDS];

   req_word_type           req_ff;
   logic [CW-1:0]          size_ff;
   logic [AW-1:0]          pos_ff;
   logic [KEY_BITS-1:0]    cur_key_ff, lk_ff, q_key_ff, removed_key_ff;
   logic [ID_BITS-1:0]     cur_id_ff, lid_ff, q_id_ff, removed_id_ff;
   logic [AW-1:0]          q_slot_ff;
   logic                   q_present_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic [CLW-1:0]         clr_ff;
   logic                   out_valid_ff;
   rsp_word_type           out_word_ff;

   logic [LW-1:0]       l_w, r_w, size_w;
   logic [AW-1:0]       parent;
   logic                no_left, has_right, use_right;
   logic [KEY_BITS-1:0] ck, ins_key, dec_key;
   logic [ID_BITS-1:0]  cid;
   logic [AW-1:0]       c_pos;
   logic [EW-1:0]       ins_ext, dec_ext, root_ext, rem_ext;
   logic                rd_en, kw_en;
   logic [AW-1:0]       rd_addr, kw_addr;
   logic [KEY_BITS-1:0] kw_key;
   logic [ID_BITS-1:0]  kw_id;
   logic [CW+COUNT_OUT_BITS-1:0] count_w;

   // Tree geometry of the current slot.
   assign l_w       = LW'({pos_ff, 1'b1});
   assign r_w       = l_w + LW'(1);
   assign size_w    = LW'(size_ff);
   assign no_left   = l_w >= size_w;
   assign has_right = r_w < size_w;
   assign parent    = (pos_ff - AW'(1)) >> 1;

   // Child choice: the right child, if present, wins unless the left one is strictly smaller.
   assign use_right = has_right && !($signed(lk_ff) < $signed(q_key_ff));
   assign ck        = use_right ? q_key_ff : lk_ff;
   assign cid       = use_right ? q_id_ff : lid_ff;
   assign c_pos     = use_right ? r_w[AW-1:0] : l_w[AW-1:0];

   // Key range handling in a width that holds every intermediate value.
   assign ins_ext = {{(EW-IN_KEY_BITS){req_ff.new_key[IN_KEY_BITS-1]}}, req_ff.new_key};
   assign ins_key = ($signed(ins_ext) < $signed(KMIN)) ? KMIN[KEY_BITS-1:0] :
                    ($signed(ins_ext) > $signed(KMAX)) ? KMAX[KEY_BITS-1:0] :
                    ins_ext[KEY_BITS-1:0];
   assign dec_ext = {{(EW-KEY_BITS){q_key_ff[KEY_BITS-1]}}, q_key_ff}
                    - {{(EW-DELTA_BITS){1'b0}}, req_ff.delta};
   assign dec_key = ($signed(dec_ext) < $signed(KMIN)) ? KMIN[KEY_BITS-1:0] :
                    dec_ext[KEY_BITS-1:0];
   assign root_ext = {{(EW-KEY_BITS){q_key_ff[KEY_BITS-1]}}, q_key_ff};
   assign rem_ext  = {{(EW-KEY_BITS){removed_key_ff[KEY_BITS-1]}}, removed_key_ff};
   assign count_w  = {{COUNT_OUT_BITS{1'b0}}, size_ff};

   // Read address of the slot memories.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.op)
         DP_RD_ROOT, DP_FIN_READ: rd_en = 1'b1;
         DP_TAKE_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = AW'(size_ff - CW'(1));
         end
         DP_UP_READ: begin
            rd_en   = 1'b1;
            rd_addr = parent;
         end
         DP_DN_READ_L: begin
            rd_en   = 1'b1;
            rd_addr = l_w[AW-1:0];
         end
         DP_DN_READ_R: begin
            rd_en   = has_right;
            rd_addr = r_w[AW-1:0];
         end
         DP_DEC_READ: begin
            rd_en   = 1'b1;
            rd_addr = q_slot_ff;
         end
         default: rd_en = 1'b0;
      endcase
   end

   // Entry write: the slot map always follows the entry to its new slot.
   always_comb begin
      kw_en   = 1'b0;
      kw_addr = pos_ff;
      kw_key  = cur_key_ff;
      kw_id   = cur_id_ff;
      case (cmd.op)
         DP_UP_STEP: begin
            kw_en  = 1'b1;
            kw_key = q_key_ff;
            kw_id  = q_id_ff;
         end
         DP_DN_STEP: begin
            kw_en  = 1'b1;
            kw_key = ck;
            kw_id  = cid;
         end
         DP_PLACE: kw_en = 1'b1;
         default:  kw_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (kw_en) begin
         key_mem[kw_addr]  <= kw_key;
         item_mem[kw_addr] <= kw_id;
         slot_mem[kw_id]   <= kw_addr;
      end
      if (rd_en) begin
         q_key_ff <= key_mem[rd_addr];
         q_id_ff  <= item_mem[rd_addr];
      end
      if (cmd.op == DP_LOAD) begin
         q_slot_ff <= slot_mem[req_word.item_id];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CLEAR:     present_mem[clr_ff] <= 1'b0;
         DP_INS_START: present_mem[req_ff.item_id] <= 1'b1;
         DP_TAKE_ROOT: present_mem[q_id_ff] <= 1'b0;
         default:      ;
      endcase
      if (cmd.op == DP_LOAD) begin
         q_present_ff <= present_mem[req_word.item_id];
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            req_ff         <= req_word;
            status_ff      <= STATUS_OK;
            removed_id_ff  <= '0;
            removed_key_ff <= '0;
         end
         DP_SET_STATUS: status_ff <= cmd.status;
         DP_TAKE_ROOT: begin
            removed_id_ff  <= q_id_ff;
            removed_key_ff <= q_key_ff;
         end
         DP_LOAD_LAST: begin
            cur_key_ff <= q_key_ff;
            cur_id_ff  <= q_id_ff;
            pos_ff     <= '0;
         end
         DP_INS_START: begin
            cur_key_ff <= ins_key;
            cur_id_ff  <= req_ff.item_id;
            pos_ff     <= AW'(size_ff);
         end
         DP_DEC_READ:  pos_ff <= q_slot_ff;
         DP_DEC_APPLY: begin
            cur_key_ff <= dec_key;
            cur_id_ff  <= req_ff.item_id;
         end
         DP_UP_STEP: pos_ff <= parent;
         DP_DN_READ_R: begin
            lk_ff  <= q_key_ff;
            lid_ff <= q_id_ff;
         end
         DP_DN_STEP: pos_ff <= c_pos;
         DP_RESULT: begin
            out_word_ff.removed_id  <= removed_id_ff;
            out_word_ff.removed_key <= rem_ext[IN_KEY_BITS-1:0];
            out_word_ff.min_id      <= (size_ff == '0) ? '0 : q_id_ff;
            out_word_ff.min_key     <= (size_ff == '0) ? '0 : root_ext[IN_KEY_BITS-1:0];
            out_word_ff.is_empty    <= (size_ff == '0);
            out_word_ff.entry_count <= count_w[COUNT_OUT_BITS-1:0];
            out_word_ff.status      <= status_ff;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == DP_CLEAR) clr_ff <= clr_ff + CLW'(1);
         if (cmd.op == DP_INS_START) size_ff <= size_ff + CW'(1);
         else if (cmd.op == DP_TAKE_ROOT) size_ff <= size_ff - CW'(1);
         if (cmd.op == DP_RESULT) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.clear_done = (clr_ff == CLW'(NUM_IDS - 1));
      stat.is_present = q_present_ff;
      stat.full       = (size_ff == CW'(CAPACITY));
      stat.empty      = (size_ff == '0);
      stat.last_one   = (size_ff == CW'(1));
      stat.pos_zero   = (pos_ff == '0);
      stat.up_stop    = $signed(q_key_ff) <= $signed(cur_key_ff);
      stat.no_left    = no_left;
      stat.dn_stop    = !($signed(ck) < $signed(cur_key_ff));
      stat.slot_ok    = CW'(q_slot_ff) < size_ff;
      stat.out_busy   = out_valid_ff && !rsp_ready;
      stat.cmd        = req_ff.cmd;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `BMHQ_ASSERT_ALWAYS(a_size_bound, clock, reset, size_ff <= CW'(CAPACITY))
   `BMHQ_ASSERT_NEXT(a_result_valid, clock, reset, cmd.op == DP_RESULT, out_valid_ff)
   `BMHQ_ASSERT_NEXT(a_take_shrinks, clock, reset, cmd.op == DP_TAKE_ROOT, size_ff == $past(size_ff) - CW'(1))
   `BMHQ_ASSERT_NEXT(a_ins_grows, clock, reset, cmd.op == DP_INS_START, size_ff == $past(size_ff) + CW'(1))

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Top level of the binary min-heap priority queue with decrease-key.
// Depends on bmhq_pkg, bmhq_stream_if, bmhq_ctrl and bmhq_dp.
//
//   Channel    Direction  Word            Contents
//   req_chan   in         req_word_type   cmd, item_id, new_key, delta
//   rsp_chan   out        rsp_word_type   removed entry, minimum, count, status
//
// One command is in work at a time. Per heap level that an entry travels,
// sift-up reads the parent and sift-down reads the left and then the right
// child, through the single read port of the slot memories. After reset a
// clearing pass resets the id-present memory before the first word is taken.
// A finished word waits in the output register while the next command is
// accepted; a stalled output holds the following result until the register
// is free.
module binary_min_heap_queue import bmhq_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   bmhq_stream_if.sink   req_chan,
   bmhq_stream_if.source rsp_chan
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;
   logic         req_ready;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   // The controller sequences every command; it raises ready only when idle.
   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (dp_stat),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (ctrl_cmd)
   );

   // The datapath owns the heap memories, the working entry and the output word.
   bmhq_dp #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .stat      (dp_stat),
      .req_word  (req_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_word;

endmodule
